@@ hdl/sha1md_pkg.sv @@
// Shared types, constants and helper functions for the SHA-1 message digest block.
package sha1md_pkg;

   localparam int NUM_WORDS = 5;
   localparam int NUM_ROUNDS = 80;
   localparam int ROUNDS_PER_STAGE = 20;
   localparam int BLOCK_BITS = 512;
   localparam int LENGTH_BITS = 64;

   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] FILL_LENGTH_START = 6'd56;
   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [2:0] LAST_WORD_INDEX = 3'd4;

   localparam logic [31:0] HASH_INIT [NUM_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   typedef enum logic [1:0] {
      STAGE_CHOOSE = 2'd0,
      STAGE_PARITY_LO = 2'd1,
      STAGE_MAJORITY = 2'd2,
      STAGE_PARITY_HI = 2'd3
   } stage_type;

   typedef enum logic [1:0] {
      PUT_DATA = 2'd0,
      PUT_MARK = 2'd1,
      PUT_ZERO = 2'd2
   } put_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_LENGTH,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic        put_en;
      put_sel_type put_sel;
      logic        count_len;
      logic        put_length;
      logic        load_work;
      logic        round_en;
      stage_type   stage;
      logic        update_hash;
      logic        out_load;
      logic [2:0]  out_index;
      logic        clear_msg;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic fill_at_length;
   } dp_status_type;

   function automatic logic [31:0] round_const(stage_type stage);
      logic [31:0] k;
      case (stage)
         STAGE_CHOOSE:    k = 32'h5A827999;
         STAGE_PARITY_LO: k = 32'h6ED9EBA1;
         STAGE_MAJORITY:  k = 32'h8F1BBCDC;
         STAGE_PARITY_HI: k = 32'hCA62C1D6;
         default:         k = 32'h5A827999;
      endcase
      return k;
   endfunction

endpackage

@@ hdl/sha1md_if.sv @@
// Valid/ready channel interfaces for message bytes and digest words.
interface sha1md_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output has_byte,
                   output end_of_message, input ready);
   modport sink (input valid, input data_byte, input has_byte,
                 input end_of_message, output ready);
endinterface

interface sha1md_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink (input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface

@@ hdl/sha1md_datapath.sv @@
// Datapath: byte shift buffer, message schedule, round logic and chaining words.
module sha1md_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sha1md_pkg::dp_cmd_type cmd,
   input  logic [7:0]             data_byte,
   output sha1md_pkg::dp_status_type status,
   output logic [31:0]            digest_word
);

   logic [sha1md_pkg::BLOCK_BITS-1:0]  block_ff, block_in;
   logic [5:0]                         fill_ff, fill_in;
   logic [sha1md_pkg::LENGTH_BITS-1:0] length_ff, length_in;
   logic [31:0]                        hash_ff [sha1md_pkg::NUM_WORDS];
   logic [31:0]                        hash_in [sha1md_pkg::NUM_WORDS];
   logic [31:0]                        work_ff [sha1md_pkg::NUM_WORDS];
   logic [31:0]                        work_in [sha1md_pkg::NUM_WORDS];
   logic [31:0]                        digest_ff, digest_in;

   logic [7:0]  put_byte;
   logic [31:0] w0, w2, w8, w13, sched_x, sched_new;
   logic [31:0] f_val, temp;

   // The block is a shift register: bytes enter at the bottom, and during the
   // rounds the oldest schedule word leaves at the top.
   assign w0  = block_ff[511:480];
   assign w2  = block_ff[447:416];
   assign w8  = block_ff[255:224];
   assign w13 = block_ff[95:64];
   assign sched_x = w13 ^ w8 ^ w2 ^ w0;
   assign sched_new = {sched_x[30:0], sched_x[31]};

   always_comb begin
      case (cmd.put_sel)
         sha1md_pkg::PUT_DATA: put_byte = data_byte;
         sha1md_pkg::PUT_MARK: put_byte = sha1md_pkg::PAD_MARK_BYTE;
         sha1md_pkg::PUT_ZERO: put_byte = 8'h00;
         default:              put_byte = 8'h00;
      endcase
   end

   always_comb begin
      case (cmd.stage)
         sha1md_pkg::STAGE_CHOOSE:
            f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         sha1md_pkg::STAGE_MAJORITY:
            f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3])
                  | (work_ff[2] & work_ff[3]);
         default:
            f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
      endcase
   end

   assign temp = {work_ff[0][26:0], work_ff[0][31:27]} + f_val + work_ff[4]
               + sha1md_pkg::round_const(cmd.stage) + w0;

   always_comb begin
      block_in = block_ff;
      fill_in = fill_ff;
      length_in = length_ff;
      hash_in = hash_ff;
      work_in = work_ff;
      digest_in = digest_ff;

      if (cmd.put_en) begin
         block_in = {block_ff[sha1md_pkg::BLOCK_BITS-9:0], put_byte};
         fill_in = fill_ff + 6'd1;
      end
      if (cmd.count_len) begin
         length_in = length_ff + 64'd8;
      end
      if (cmd.put_length) begin
         block_in = {block_ff[sha1md_pkg::BLOCK_BITS-sha1md_pkg::LENGTH_BITS-1:0],
                     length_ff};
         fill_in = 6'd0;
      end
      if (cmd.load_work) begin
         work_in = hash_ff;
      end
      if (cmd.round_en) begin
         block_in = {block_ff[sha1md_pkg::BLOCK_BITS-33:0], sched_new};
         work_in[0] = temp;
         work_in[1] = work_ff[0];
         work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
      end
      if (cmd.update_hash) begin
         for (int i = 0; i < sha1md_pkg::NUM_WORDS; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end
      if (cmd.out_load) begin
         digest_in = hash_ff[cmd.out_index];
      end
      if (cmd.clear_msg) begin
         hash_in = sha1md_pkg::HASH_INIT;
         fill_in = 6'd0;
         length_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 6'd0;
         length_ff <= '0;
         hash_ff <= sha1md_pkg::HASH_INIT;
      end else begin
         fill_ff <= fill_in;
         length_ff <= length_in;
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      work_ff <= work_in;
      digest_ff <= digest_in;
   end

   assign status.fill_last = (fill_ff == sha1md_pkg::FILL_LAST);
   assign status.fill_at_length = (fill_ff == sha1md_pkg::FILL_LENGTH_START);
   assign digest_word = digest_ff;

endmodule

@@ hdl/sha1md_ctrl.sv @@
// Controller: sequences byte intake, padding, the eighty rounds and digest output.
module sha1md_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      has_byte,
   input  logic                      end_of_message,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                word_index,
   output logic                      last_word,
   input  sha1md_pkg::dp_status_type status,
   output sha1md_pkg::dp_cmd_type    cmd
);

   sha1md_pkg::state_type state_ff, state_in;
   sha1md_pkg::state_type return_ff, return_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] out_idx_ff, out_idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] word_index_ff, word_index_in;
   logic       last_word_ff, last_word_in;
   logic       accept;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1md_pkg::ST_IDLE;
         return_ff <= sha1md_pkg::ST_IDLE;
         round_ff <= 7'd0;
         out_idx_ff <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         return_ff <= return_in;
         round_ff <= round_in;
         out_idx_ff <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_index_ff <= word_index_in;
      last_word_ff <= last_word_in;
   end

   always_comb begin
      state_in = state_ff;
      return_in = return_ff;
      round_in = round_ff;
      out_idx_in = out_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      word_index_in = word_index_ff;
      last_word_in = last_word_ff;
      req_ready = 1'b0;
      cmd = '0;
      cmd.put_sel = sha1md_pkg::PUT_DATA;

      if (round_ff < 7'(sha1md_pkg::ROUNDS_PER_STAGE)) begin
         cmd.stage = sha1md_pkg::STAGE_CHOOSE;
      end else if (round_ff < 7'(2 * sha1md_pkg::ROUNDS_PER_STAGE)) begin
         cmd.stage = sha1md_pkg::STAGE_PARITY_LO;
      end else if (round_ff < 7'(3 * sha1md_pkg::ROUNDS_PER_STAGE)) begin
         cmd.stage = sha1md_pkg::STAGE_MAJORITY;
      end else begin
         cmd.stage = sha1md_pkg::STAGE_PARITY_HI;
      end

      case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (has_byte) begin
                  cmd.put_en = 1'b1;
                  cmd.put_sel = sha1md_pkg::PUT_DATA;
                  cmd.count_len = 1'b1;
               end
               if (has_byte && status.fill_last) begin
                  return_in = end_of_message ? sha1md_pkg::ST_PAD_MARK
                                             : sha1md_pkg::ST_IDLE;
                  state_in = sha1md_pkg::ST_LOAD;
               end else if (end_of_message) begin
                  state_in = sha1md_pkg::ST_PAD_MARK;
               end
            end
         end
         sha1md_pkg::ST_PAD_MARK: begin
            cmd.put_en = 1'b1;
            cmd.put_sel = sha1md_pkg::PUT_MARK;
            return_in = sha1md_pkg::ST_PAD_ZERO;
            state_in = status.fill_last ? sha1md_pkg::ST_LOAD : sha1md_pkg::ST_PAD_ZERO;
         end
         sha1md_pkg::ST_PAD_ZERO: begin
            if (status.fill_at_length) begin
               state_in = sha1md_pkg::ST_LENGTH;
            end else begin
               cmd.put_en = 1'b1;
               cmd.put_sel = sha1md_pkg::PUT_ZERO;
               return_in = sha1md_pkg::ST_PAD_ZERO;
               if (status.fill_last) begin
                  state_in = sha1md_pkg::ST_LOAD;
               end
            end
         end
         sha1md_pkg::ST_LENGTH: begin
            cmd.put_length = 1'b1;
            return_in = sha1md_pkg::ST_OUTPUT;
            out_idx_in = 3'd0;
            state_in = sha1md_pkg::ST_LOAD;
         end
         sha1md_pkg::ST_LOAD: begin
            cmd.load_work = 1'b1;
            round_in = 7'd0;
            state_in = sha1md_pkg::ST_ROUND;
         end
         sha1md_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (round_ff == 7'(sha1md_pkg::NUM_ROUNDS - 1)) begin
               round_in = 7'd0;
               state_in = sha1md_pkg::ST_UPDATE;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         sha1md_pkg::ST_UPDATE: begin
            cmd.update_hash = 1'b1;
            state_in = return_ff;
         end
         sha1md_pkg::ST_OUTPUT: begin
            // A new word is loaded once the previous one has been transferred.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               cmd.out_index = out_idx_ff;
               rsp_valid_in = 1'b1;
               word_index_in = out_idx_ff;
               last_word_in = (out_idx_ff == sha1md_pkg::LAST_WORD_INDEX);
               if (out_idx_ff == sha1md_pkg::LAST_WORD_INDEX) begin
                  cmd.clear_msg = 1'b1;
                  out_idx_in = 3'd0;
                  state_in = sha1md_pkg::ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = sha1md_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign word_index = word_index_ff;
   assign last_word = last_word_ff;

endmodule

@@ hdl/sha1_message_digest.sv @@
// SHA-1 digest of a byte stream. A byte that does not complete a 64-byte block is accepted
// without a stall. A byte that completes a block starts a compression in the single round
// unit: the working words are loaded, 80 rounds run at one per cycle and the results are
// added into the chaining words. End of message then puts in the padding bytes one by one,
// takes a further step once the zero padding reaches the length field, puts in the bit
// length and runs one or two further compressions, after which the five digest words
// leave one per cycle as the output register is freed. While the message is taken in the
// input side is ready; it is held off during compression, padding and digest output.
module sha1_message_digest (
   input logic        clock,
   input logic        reset,
   sha1md_req_if.sink req_if,
   sha1md_rsp_if.source rsp_if
);

   sha1md_pkg::dp_cmd_type    cmd;
   sha1md_pkg::dp_status_type status;

   sha1md_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .has_byte       (req_if.has_byte),
      .end_of_message (req_if.end_of_message),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .word_index     (rsp_if.word_index),
      .last_word      (rsp_if.last_word),
      .status         (status),
      .cmd            (cmd)
   );

   sha1md_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_if.data_byte),
      .status      (status),
      .digest_word (rsp_if.digest_word)
   );

endmodule

@@ sim/sha1_message_digest_test.sv @@
// Self-checking testbench for the SHA-1 message digest block, predicting every digest word.
module sha1_message_digest_test;

   localparam logic [31:0] IV_H0 = 32'h67452301;
   localparam logic [31:0] IV_H1 = 32'hEFCDAB89;
   localparam logic [31:0] IV_H2 = 32'h98BADCFE;
   localparam logic [31:0] IV_H3 = 32'h10325476;
   localparam logic [31:0] IV_H4 = 32'hC3D2E1F0;
   localparam logic [31:0] K_CHOOSE = 32'h5A827999;
   localparam logic [31:0] K_PARITY_LO = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
   localparam logic [31:0] K_PARITY_HI = 32'hCA62C1D6;
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam int unsigned LENGTH_FILL = 56;
   localparam int unsigned DIGEST_WORDS = 5;
   localparam int unsigned MAX_GAP = 6;
   localparam int unsigned LONG_HOLD_OFF = 300;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   logic clock;
   logic reset;

   sha1md_req_if req_if ();
   sha1md_rsp_if rsp_if ();

   sha1_message_digest i_dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // Predicted state of the digest engine.
   logic [31:0] chain_q [5];
   logic [31:0] block_q [16];
   int unsigned fill_q;
   logic [63:0] bitlen_q;

   digest_beat_type digest_expect [$];
   digest_beat_type want;
   int unsigned n_mismatch;
   int unsigned hold_off_cycles;
   bit steady_flow;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void sha1_restart();
      chain_q[0] = IV_H0;
      chain_q[1] = IV_H1;
      chain_q[2] = IV_H2;
      chain_q[3] = IV_H3;
      chain_q[4] = IV_H4;
      fill_q = 0;
      bitlen_q = 64'd0;
   endfunction

   function automatic void sha1_compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t;
      int r;
      for (r = 0; r < 16; r++) w[r] = block_q[r];
      a = chain_q[0];
      b = chain_q[1];
      c = chain_q[2];
      d = chain_q[3];
      e = chain_q[4];
      for (r = 0; r < 80; r++) begin
         // The schedule is kept as a sliding window of sixteen words.
         if (r >= 16) begin
            w[r & 15] = rotl32(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15]
                               ^ w[r & 15], 1);
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K_CHOOSE;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_PARITY_LO;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_MAJORITY;
         end else begin
            f = b ^ c ^ d;
            k = K_PARITY_HI;
         end
         t = rotl32(a, 5) + f + e + k + w[r & 15];
         e = d;
         d = c;
         c = rotl32(b, 30);
         b = a;
         a = t;
      end
      chain_q[0] = chain_q[0] + a;
      chain_q[1] = chain_q[1] + b;
      chain_q[2] = chain_q[2] + c;
      chain_q[3] = chain_q[3] + d;
      chain_q[4] = chain_q[4] + e;
   endfunction

   function automatic void sha1_put_byte(input logic [7:0] value);
      int unsigned shift;
      shift = (3 - fill_q % 4) * 8;
      if (fill_q % 4 == 0) begin
         block_q[fill_q / 4] = {24'd0, value} << shift;
      end else begin
         block_q[fill_q / 4] = block_q[fill_q / 4] | ({24'd0, value} << shift);
      end
      fill_q = fill_q + 1;
      if (fill_q == 64) begin
         sha1_compress();
         fill_q = 0;
      end
   endfunction

   function automatic void sha1_absorb(input logic [7:0] value, input logic with_byte,
                                       input logic closes);
      digest_beat_type beat;
      int unsigned i;
      if (with_byte) begin
         sha1_put_byte(value);
         bitlen_q = bitlen_q + 64'd8;
      end
      if (closes) begin
         sha1_put_byte(PAD_MARK);
         while (fill_q != LENGTH_FILL) sha1_put_byte(8'h00);
         block_q[14] = bitlen_q[63:32];
         block_q[15] = bitlen_q[31:0];
         sha1_compress();
         for (i = 0; i < DIGEST_WORDS; i++) begin
            beat.digest_word = chain_q[i];
            beat.word_index = i[2:0];
            beat.last_word = (i == DIGEST_WORDS - 1);
            digest_expect.insert(digest_expect.size(), beat);
         end
         sha1_restart();
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   // Sends one item after a random gap (none in steady flow); the expectation is updated on the transfer.
   task automatic send_item(input logic [7:0] value, input logic with_byte,
                            input logic closes);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         req_if.data_byte <= 8'($urandom_range(0, 255));
         req_if.has_byte <= 1'($urandom_range(0, 1));
         req_if.end_of_message <= 1'($urandom_range(0, 1));
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.data_byte <= value;
      req_if.has_byte <= with_byte;
      req_if.end_of_message <= closes;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      sha1_absorb(value, with_byte, closes);
   endtask

   task automatic send_message(input int unsigned len);
      int unsigned n;
      logic tail_closes;
      tail_closes = (len > 0) && ($urandom_range(0, 1) == 1);
      for (n = 0; n < len; n++) begin
         if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, tail_closes && (n == len - 1));
      end
      if (!tail_closes) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task automatic test_directed_corners();
      // Empty message, with a data byte that must be ignored.
      send_item(8'hFF, 1'b0, 1'b1);
      // Idle item ahead of the classic three-byte message.
      send_item(8'h5A, 1'b0, 1'b0);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // Byte extremes, then a close that carries no byte.
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h80, 1'b1, 1'b1);
      send_item(8'h01, 1'b1, 1'b0);
      send_item(8'hFE, 1'b0, 1'b1);
   endtask

   // A full block mid-message and a length field that spills into a second block.
   task automatic test_multi_block();
      send_message($urandom_range(120, 123));
   endtask

   task automatic test_random_messages();
      repeat (4) send_message($urandom_range(0, 6));
   endtask

   task automatic test_steady_flow();
      steady_flow = 1'b1;
      repeat (2) send_message($urandom_range(0, 4));
      steady_flow = 1'b0;
   endtask

   // The receiver stalls for a long while so that the input side must back off.
   task automatic test_output_backpressure();
      hold_off_cycles = LONG_HOLD_OFF;
      repeat (3) send_message($urandom_range(1, 3));
   endtask

   initial begin : digest_sink
      int unsigned stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else if (steady_flow) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (digest_expect.size() == 0) begin
            $error("unexpected digest word: digest_word %h word_index %0d last_word %0b",
                   rsp_if.digest_word, rsp_if.word_index, rsp_if.last_word);
            n_mismatch = n_mismatch + 1;
         end else begin
            want = digest_expect.pop_front();
            if (rsp_if.digest_word !== want.digest_word) begin
               $error("digest_word: expected %h, got %h", want.digest_word,
                      rsp_if.digest_word);
               n_mismatch = n_mismatch + 1;
            end
            if (rsp_if.word_index !== want.word_index) begin
               $error("word_index: expected %0d, got %0d", want.word_index,
                      rsp_if.word_index);
               n_mismatch = n_mismatch + 1;
            end
            if (rsp_if.last_word !== want.last_word) begin
               $error("last_word: expected %0b, got %0b", want.last_word, rsp_if.last_word);
               n_mismatch = n_mismatch + 1;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.has_byte = 1'b0;
      req_if.end_of_message = 1'b0;
      n_mismatch = 0;
      hold_off_cycles = 0;
      steady_flow = 1'b0;
      sha1_restart();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_multi_block();
      test_random_messages();
      test_steady_flow();
      test_output_backpressure();

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (digest_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (n_mismatch == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
